/* design/bmhq_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants of the binary min-heap priority queue.
// Used by the controller, the datapath, the top level and the checker.
package bmhq_pkg;

   // Default number of keys the queue can hold.
   localparam int CAPACITY_DEF = 4096;

   // Field widths fixed by the external interface.
   localparam int KEY_W   = 32;
   localparam int CMD_W   = 2;
   localparam int STAT_W  = 2;
   localparam int COUNT_W = 13;

   // Command codes.
   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_POP    = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

   // Status codes.
   localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
   localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

   // Controller states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_UP_TEST,
      ST_UP_CMP,
      ST_POP_LAST,
      ST_POP_LOAD,
      ST_DN_TEST,
      ST_DN_LEFT,
      ST_DN_RIGHT,
      ST_DN_CMP
   } state_type;

   // Update of the entry count.
   typedef enum logic [1:0] {
      FILL_HOLD,
      FILL_INC,
      FILL_DEC,
      FILL_CLEAR
   } fill_op_type;

   // Update of the current heap position.
   typedef enum logic [2:0] {
      POS_HOLD,
      POS_NEW,
      POS_PARENT,
      POS_ROOT,
      POS_PICK
   } pos_op_type;

   // Heap slot that a memory read fetches.
   typedef enum logic [2:0] {
      RD_PARENT,
      RD_ROOT,
      RD_LAST,
      RD_LEFT,
      RD_RIGHT
   } rd_sel_type;

   // Value that a memory write stores at the current position.
   typedef enum logic [1:0] {
      WR_KEY,
      WR_RDATA,
      WR_CHILD
   } wr_sel_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic              load_new;
      fill_op_type       fill_op;
      pos_op_type        pos_op;
      logic              rd_en;
      rd_sel_type        rd_sel;
      logic              wr_en;
      wr_sel_type        wr_sel;
      logic              load_top;
      logic              load_key;
      logic              load_left;
      logic              load_right;
      logic              respond;
      logic [STAT_W-1:0] status;
      logic              give_top;
   } bmhq_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic full;
      logic empty;
      logic at_root;
      logic key_lt_rdata;
      logic no_left;
      logic no_right;
      logic key_le_child;
   } bmhq_sts_type;

endpackage

/* design/bmhq_ctrl.sv */
`timescale 1ns / 1ps
// Controller of the min-heap queue: sequences inserts, pops and clears.
// Depends on bmhq_pkg for the state, command and status types.
module bmhq_ctrl import bmhq_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [CMD_W-1:0]   req_command,
   input  bmhq_sts_type       sts,
   output logic               busy,
   output bmhq_cmd_type       cmd
);

   state_type state_ff;
   state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

   // Next-state logic.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_command == CMD_INSERT && !sts.full) begin
                  state_in = ST_UP_TEST;
               end else if (req_command == CMD_POP && !sts.empty) begin
                  state_in = ST_POP_LAST;
               end
            end
         end
         ST_UP_TEST: begin
            state_in = sts.at_root ? ST_IDLE : ST_UP_CMP;
         end
         ST_UP_CMP: begin
            state_in = sts.key_lt_rdata ? ST_UP_TEST : ST_IDLE;
         end
         ST_POP_LAST: state_in = ST_POP_LOAD;
         ST_POP_LOAD: state_in = ST_DN_TEST;
         ST_DN_TEST: begin
            state_in = sts.no_left ? ST_IDLE : ST_DN_LEFT;
         end
         ST_DN_LEFT: begin
            state_in = sts.no_right ? ST_DN_CMP : ST_DN_RIGHT;
         end
         ST_DN_RIGHT: state_in = ST_DN_CMP;
         ST_DN_CMP: begin
            state_in = sts.key_le_child ? ST_IDLE : ST_DN_TEST;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Command outputs to the datapath.
   always_comb begin
      cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (req_command)
                  CMD_INSERT: begin
                     if (sts.full) begin
                        cmd.respond = 1'b1;
                        cmd.status  = STAT_FULL;
                     end else begin
                        cmd.load_new = 1'b1;
                        cmd.fill_op  = FILL_INC;
                        cmd.pos_op   = POS_NEW;
                     end
                  end
                  CMD_POP: begin
                     if (sts.empty) begin
                        cmd.respond = 1'b1;
                        cmd.status  = STAT_EMPTY;
                     end else begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = RD_ROOT;
                     end
                  end
                  CMD_CLEAR: begin
                     cmd.fill_op = FILL_CLEAR;
                     cmd.respond = 1'b1;
                     cmd.status  = STAT_OK;
                  end
                  default: begin
                     cmd.respond = 1'b1;
                     cmd.status  = STAT_OK;
                  end
               endcase
            end
         end
         ST_UP_TEST: begin
            if (sts.at_root) begin
               cmd.wr_en   = 1'b1;
               cmd.wr_sel  = WR_KEY;
               cmd.respond = 1'b1;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_PARENT;
            end
         end
         ST_UP_CMP: begin
            cmd.wr_en = 1'b1;
            if (sts.key_lt_rdata) begin
               // Parent moves down into the hole; the hole moves up.
               cmd.wr_sel = WR_RDATA;
               cmd.pos_op = POS_PARENT;
            end else begin
               cmd.wr_sel  = WR_KEY;
               cmd.respond = 1'b1;
            end
         end
         ST_POP_LAST: begin
            cmd.load_top = 1'b1;
            cmd.rd_en    = 1'b1;
            cmd.rd_sel   = RD_LAST;
         end
         ST_POP_LOAD: begin
            cmd.load_key = 1'b1;
            cmd.fill_op  = FILL_DEC;
            cmd.pos_op   = POS_ROOT;
         end
         ST_DN_TEST: begin
            if (sts.no_left) begin
               cmd.wr_en    = 1'b1;
               cmd.wr_sel   = WR_KEY;
               cmd.respond  = 1'b1;
               cmd.give_top = 1'b1;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_LEFT;
            end
         end
         ST_DN_LEFT: begin
            cmd.load_left = 1'b1;
            if (!sts.no_right) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_RIGHT;
            end
         end
         ST_DN_RIGHT: begin
            cmd.load_right = 1'b1;
         end
         ST_DN_CMP: begin
            cmd.wr_en = 1'b1;
            if (sts.key_le_child) begin
               cmd.wr_sel   = WR_KEY;
               cmd.respond  = 1'b1;
               cmd.give_top = 1'b1;
            end else begin
               // Smaller child moves up into the hole; the hole moves down.
               cmd.wr_sel = WR_CHILD;
               cmd.pos_op = POS_PICK;
            end
         end
         default: cmd = '0;
      endcase
   end

endmodule

/* design/bmhq_datapath.sv */
`timescale 1ns / 1ps
// Datapath of the min-heap queue: key memory, position and count registers,
// comparators and the registered result. Depends on bmhq_pkg.
module bmhq_datapath import bmhq_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic signed [KEY_W-1:0]   req_value,
   input  bmhq_cmd_type              cmd,
   output bmhq_sts_type              sts,
   output logic                      rsp_valid,
   output logic signed [KEY_W-1:0]   rsp_popped_value,
   output logic [STAT_W-1:0]         rsp_status,
   output logic [COUNT_W-1:0]        rsp_entry_count
);

   // Memory index width and position width (positions run 1..CAPACITY).
   localparam int AW = $clog2(CAPACITY);
   localparam int PW = $clog2(CAPACITY + 1);

   logic signed [KEY_W-1:0] mem [CAPACITY];
   logic signed [KEY_W-1:0] rdata_ff;

   logic [PW-1:0]           fill_ff;
   logic [PW-1:0]           fill_in;
   logic [PW-1:0]           pos_ff;
   logic [PW-1:0]           pos_in;
   logic [PW-1:0]           pick_ff;
   logic signed [KEY_W-1:0] key_ff;
   logic signed [KEY_W-1:0] child_ff;
   logic signed [KEY_W-1:0] top_ff;

   logic                    rsp_valid_ff;
   logic signed [KEY_W-1:0] rsp_popped_value_ff;
   logic [STAT_W-1:0]       rsp_status_ff;
   logic [COUNT_W-1:0]      rsp_entry_count_ff;

   logic [PW:0]             l_idx;
   logic [PW:0]             r_idx;
   logic [PW-1:0]           rd_pos;
   logic [AW-1:0]           rd_addr;
   logic [AW-1:0]           wr_addr;
   logic signed [KEY_W-1:0] wr_data;

   // Child positions of the current slot, one bit wider than a position.
   assign l_idx = {pos_ff, 1'b0};
   assign r_idx = l_idx + (PW + 1)'(1);

   // Status toward the controller.
   assign sts.full         = (fill_ff == PW'(CAPACITY));
   assign sts.empty        = (fill_ff == '0);
   assign sts.at_root      = (pos_ff == PW'(1));
   assign sts.key_lt_rdata = (key_ff < rdata_ff);
   assign sts.no_left      = (l_idx > {1'b0, fill_ff});
   assign sts.no_right     = (r_idx > {1'b0, fill_ff});
   assign sts.key_le_child = (key_ff <= child_ff);

   // Read slot selection; slot n lives at memory index n - 1.
   always_comb begin
      case (cmd.rd_sel)
         RD_PARENT: rd_pos = pos_ff >> 1;
         RD_ROOT:   rd_pos = PW'(1);
         RD_LAST:   rd_pos = fill_ff;
         RD_LEFT:   rd_pos = l_idx[PW-1:0];
         RD_RIGHT:  rd_pos = r_idx[PW-1:0];
         default:   rd_pos = PW'(1);
      endcase
   end

   assign rd_addr = AW'(rd_pos - PW'(1));
   assign wr_addr = AW'(pos_ff - PW'(1));

   // Write data selection.
   always_comb begin
      case (cmd.wr_sel)
         WR_KEY:   wr_data = key_ff;
         WR_RDATA: wr_data = rdata_ff;
         WR_CHILD: wr_data = child_ff;
         default:  wr_data = key_ff;
      endcase
   end

   // Key memory with one write port and one registered read port.
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   // Next entry count.
   always_comb begin
      case (cmd.fill_op)
         FILL_HOLD:  fill_in = fill_ff;
         FILL_INC:   fill_in = fill_ff + PW'(1);
         FILL_DEC:   fill_in = fill_ff - PW'(1);
         FILL_CLEAR: fill_in = '0;
         default:    fill_in = fill_ff;
      endcase
   end

   // Next hole position.
   always_comb begin
      case (cmd.pos_op)
         POS_HOLD:   pos_in = pos_ff;
         POS_NEW:    pos_in = fill_ff + PW'(1);
         POS_PARENT: pos_in = pos_ff >> 1;
         POS_ROOT:   pos_in = PW'(1);
         POS_PICK:   pos_in = pick_ff;
         default:    pos_in = pos_ff;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         rsp_valid_ff <= cmd.respond;
      end
   end

   // Working registers of the sift loops.
   always_ff @(posedge clock) begin
      pos_ff <= pos_in;
      if (cmd.load_new) begin
         key_ff <= req_value;
      end else if (cmd.load_key) begin
         key_ff <= rdata_ff;
      end
      if (cmd.load_top) begin
         top_ff <= rdata_ff;
      end
      if (cmd.load_left) begin
         child_ff <= rdata_ff;
         pick_ff  <= l_idx[PW-1:0];
      end else if (cmd.load_right && (rdata_ff < child_ff)) begin
         // The right child wins only when strictly smaller than the left.
         child_ff <= rdata_ff;
         pick_ff  <= r_idx[PW-1:0];
      end
   end

   // Result registers, loaded in the cycle that finishes a command.
   always_ff @(posedge clock) begin
      if (cmd.respond) begin
         rsp_popped_value_ff <= cmd.give_top ? top_ff : '0;
         rsp_status_ff       <= cmd.status;
         rsp_entry_count_ff  <= COUNT_W'(fill_in);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_popped_value = rsp_popped_value_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_entry_count  = rsp_entry_count_ff;

endmodule

/* design/binary_min_heap_queue_top.sv */
`timescale 1ns / 1ps
// Top level of the binary min-heap priority queue: controller plus datapath.
// Depends on bmhq_pkg, bmhq_ctrl and bmhq_datapath.
//
// A command is taken when start is high and busy is low; exactly one result
// follows, shown for one cycle with rsp_valid high, and the receiver must
// take it then. Keys live in a single-port-write, single-port-read memory of
// CAPACITY entries, and that read port sets the timing: a clear, a rejected
// command or an unused code answers in the cycle right after the transfer
// without raising busy. An insert keeps busy high while, level by level, it
// tests for the root, then reads the parent and moves it down while the key
// is smaller; the key is written where it stops. A pop keeps busy high while
// it reads the root and the last key, then level by level tests for a left
// child, reads the left and any right child, and moves the smaller child up
// until the key reaches a leaf or is no larger than it. busy drops in the
// cycle the result appears, so the next command may be transferred while the
// previous result is on the ports. There is no clearing pass after reset:
// the entry count alone tells which slots hold keys.
module binary_min_heap_queue_top import bmhq_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [CMD_W-1:0]          req_command,
   input  logic signed [KEY_W-1:0]   req_value,
   output logic                      rsp_valid,
   output logic signed [KEY_W-1:0]   rsp_popped_value,
   output logic [STAT_W-1:0]         rsp_status,
   output logic [COUNT_W-1:0]        rsp_entry_count
);

   bmhq_cmd_type cmd;
   bmhq_sts_type sts;

   // Sequencer.
   bmhq_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_command (req_command),
      .sts         (sts),
      .busy        (busy),
      .cmd         (cmd)
   );

   // Storage and arithmetic.
   bmhq_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_value        (req_value),
      .cmd              (cmd),
      .sts              (sts),
      .rsp_valid        (rsp_valid),
      .rsp_popped_value (rsp_popped_value),
      .rsp_status       (rsp_status),
      .rsp_entry_count  (rsp_entry_count)
   );

endmodule

/* design/bmhq_checker.sv */
`timescale 1ns / 1ps
// Port-level checks of the min-heap queue, bound to the top level.
// Depends on bmhq_pkg and binary_min_heap_queue_top.
module bmhq_checker import bmhq_pkg::*; (
   input logic                      clock,
   input logic                      reset,
   input logic                      start,
   input logic                      busy,
   input logic [CMD_W-1:0]          req_command,
   input logic                      rsp_valid,
   input logic signed [KEY_W-1:0]   rsp_popped_value,
   input logic [STAT_W-1:0]         rsp_status,
   input logic [COUNT_W-1:0]        rsp_entry_count
);

   // A transfer either answers at once or keeps the block busy.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_valid))
      else $error("transfer neither answered nor started work");

   // A result appears only once the block has finished its command.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while still busy");

   // A clear answers next cycle with status ok and an empty queue.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_command == CMD_CLEAR) |=>
         (rsp_valid && rsp_status == STAT_OK && rsp_entry_count == '0))
      else $error("clear did not empty the queue");

   // Rejected commands return no key.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != STAT_OK) |-> (rsp_popped_value == '0))
      else $error("rejected command returned a key");

   // A pop on an empty queue reports an empty count.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STAT_EMPTY) |-> (rsp_entry_count == '0))
      else $error("empty status with nonzero count");

endmodule

bind binary_min_heap_queue_top bmhq_checker u_bmhq_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .req_command      (req_command),
   .rsp_valid        (rsp_valid),
   .rsp_popped_value (rsp_popped_value),
   .rsp_status       (rsp_status),
   .rsp_entry_count  (rsp_entry_count)
);
